// ----- hdl/abt_pkg.sv -----
// shared constants, codes and saturation helpers for the absorbing boundary traction core
`timescale 1ns / 1ps

package abt_pkg;

    localparam int NORM_W   = 18;
    localparam int VEL_W    = 32;
    localparam int MOD_W    = 40;
    localparam int RHO_W    = 16;
    localparam int TR_W     = 64;
    localparam int M_W      = MOD_W + 2;
    localparam int RAD_W    = RHO_W + M_W;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int NV_W     = NORM_W + VEL_W;
    localparam int Q_W      = 36;
    localparam int QN_W     = Q_W + NORM_W;
    localparam int P_W      = 37;
    localparam int PP_W     = ROOT_W + 1 + 19;
    localparam int PROD_W   = PP_W + 18;
    localparam int IN_DATA_W  = 248;
    localparam int OUT_DATA_W = 3 * TR_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = MOD_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIMS      = 3'd0,
        CFG_USE_POINT = 3'd1,
        CFG_LAMBDA    = 3'd2,
        CFG_MU        = 3'd3,
        CFG_RHO       = 3'd4
    } cfg_index_t;

    // per-point data carried alongside the square root stages
    typedef struct packed {
        logic signed [P_W-1:0] p_x;
        logic signed [P_W-1:0] p_y;
        logic signed [P_W-1:0] p_z;
        logic signed [P_W-1:0] w_x;
        logic signed [P_W-1:0] w_y;
        logic signed [P_W-1:0] w_z;
        logic                  kill;
        logic                  bad;
        logic [2:0]            mask;
    } side_t;

    function automatic logic signed [TR_W-1:0] sat_prod(input logic signed [PROD_W-1:0] v);
        logic signed [TR_W-1:0] r;
        if (v[PROD_W-1:TR_W-1] == '0 || v[PROD_W-1:TR_W-1] == '1)
            r = v[TR_W-1:0];
        else if (v[PROD_W-1])
            r = {1'b1, {(TR_W-1){1'b0}}};
        else
            r = {1'b0, {(TR_W-1){1'b1}}};
        return r;
    endfunction

    function automatic logic signed [TR_W-1:0] sat_sum(input logic signed [TR_W-1:0] a,
                                                       input logic signed [TR_W-1:0] b);
        logic signed [TR_W:0] s;
        logic signed [TR_W-1:0] r;
        s = {a[TR_W-1], a} + {b[TR_W-1], b};
        if (s[TR_W] == s[TR_W-1])
            r = s[TR_W-1:0];
        else if (s[TR_W])
            r = {1'b1, {(TR_W-1){1'b0}}};
        else
            r = {1'b0, {(TR_W-1){1'b1}}};
        return r;
    endfunction

endpackage

// ----- hdl/abt_isqrt.sv -----
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps

module abt_isqrt #(
    parameter int RAD_W = 58
) (
    input  logic                 clk,
    input  logic [RAD_W/2-1:0]   en,
    input  logic [RAD_W-1:0]     rad,
    output logic [RAD_W/2-1:0]   root
);

    localparam int ROOT_W = RAD_W / 2;

    logic [RAD_W:0] rem_reg  [ROOT_W];
    logic [RAD_W:0] res_reg  [ROOT_W];
    logic [RAD_W:0] rem_next [ROOT_W];
    logic [RAD_W:0] res_next [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        localparam logic [RAD_W:0] BIT = (RAD_W+1)'(1) << (2 * (ROOT_W - 1 - s));
        logic [RAD_W:0] rin;
        logic [RAD_W:0] qin;
        logic [RAD_W:0] trial;

        if (s == 0) begin : g_first
            assign rin = {1'b0, rad};
            assign qin = '0;
        end else begin : g_rest
            assign rin = rem_reg[s-1];
            assign qin = res_reg[s-1];
        end

        assign trial = qin + BIT;

        always_comb
        begin
            if (rin >= trial)
            begin
                rem_next[s] = rin - trial;
                res_next[s] = (qin >> 1) + BIT;
            end
            else
            begin
                rem_next[s] = rin;
                res_next[s] = qin >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                rem_reg[s] <= rem_next[s];
                res_reg[s] <= res_next[s];
            end
        end
    end

    assign root = res_reg[ROOT_W-1][ROOT_W-1:0];

endmodule

// ----- hdl/absorbing_boundary_traction_core.sv -----
// top level: absorbing boundary traction pipeline with configuration registers
//
// channel  direction  handshake            payload
// s_*      in         s_tvalid/s_tready    tdata: normals, velocity, material; tuser: has_velocity
// m_*      out        m_tvalid/m_tready    tdata: traction x/y/z; tuser: bad_material
// cfg_*    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one point per cycle sustained while m_tready is high
// the two parallel square root pipelines have 29 stages each
// every stage advances when it or any stage after it is empty or m_tready is high, so bubbles collapse
// a stalled output holds its result; the input keeps taking points until the pipe is full
// rst_n clears valid bits and loads register defaults; configuration is always ready
`timescale 1ns / 1ps

module absorbing_boundary_traction_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // normal_x, normal_y, normal_z, vel_x, vel_y, vel_z, point_lambda, point_mu, point_rho
    input  logic [abt_pkg::IN_DATA_W-1:0]    s_tdata,
    // has_velocity
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // traction_x, traction_y, traction_z
    output logic [abt_pkg::OUT_DATA_W-1:0]   m_tdata,
    // bad_material
    output logic                             m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [abt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [abt_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import abt_pkg::*;

    localparam int SQ_FIRST = 2;
    localparam int SQ_LAST  = SQ_FIRST + ROOT_W - 1;
    localparam int SIDE_ST  = 4;
    localparam int MUL_ST   = SQ_LAST + 1;
    localparam int CMB_ST   = MUL_ST + 1;
    localparam int OUT_ST   = CMB_ST + 1;
    localparam int N_ST     = OUT_ST + 1;

    // configuration registers
    logic [1:0]       dims_reg;
    logic             use_pt_reg;
    logic [MOD_W-1:0] lam_reg;
    logic [MOD_W-1:0] mu_reg;
    logic [RHO_W-1:0] rho_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg   <= 2'd3;
            use_pt_reg <= 1'b0;
            lam_reg    <= '0;
            mu_reg     <= '0;
            rho_reg    <= RHO_W'(1000);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_DIMS:      dims_reg   <= cfg_data[1:0];
                CFG_USE_POINT: use_pt_reg <= cfg_data[0];
                CFG_LAMBDA:    lam_reg    <= cfg_data[MOD_W-1:0];
                CFG_MU:        mu_reg     <= cfg_data[MOD_W-1:0];
                CFG_RHO:       rho_reg    <= cfg_data[RHO_W-1:0];
                default:       ;
            endcase
        end
    end

    // valid chain with per-stage enables
    logic [N_ST-1:0] valid_reg;
    logic [N_ST:0]   en;

    always_comb
    begin
        en[N_ST] = m_tready;
        for (int i = N_ST - 1; i >= 0; i--)
            en[i] = !valid_reg[i] || en[i+1];
    end

    assign s_tready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            for (int i = 0; i < N_ST; i++)
            begin
                if (en[i])
                    valid_reg[i] <= (i == 0) ? s_tvalid : valid_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    // stage 0: unpack, select material, mask components
    logic signed [NORM_W-1:0] n_in [3];
    logic signed [VEL_W-1:0]  v_in [3];
    logic [MOD_W-1:0]         lam_sel;
    logic [MOD_W-1:0]         mu_sel;
    logic [RHO_W-1:0]         rho_sel;
    logic [2:0]               mask_in;

    always_comb
    begin
        n_in[0] = s_tdata[17:0];
        n_in[1] = s_tdata[35:18];
        n_in[2] = s_tdata[53:36];
        v_in[0] = s_tdata[85:54];
        v_in[1] = s_tdata[117:86];
        v_in[2] = s_tdata[149:118];
        lam_sel = use_pt_reg ? s_tdata[189:150] : lam_reg;
        mu_sel  = use_pt_reg ? s_tdata[229:190] : mu_reg;
        rho_sel = use_pt_reg ? s_tdata[245:230] : rho_reg;
        for (int d = 0; d < 3; d++)
            mask_in[d] = {1'b0, dims_reg} > 3'(d);
    end

    logic signed [NORM_W-1:0] n0_reg [3];
    logic signed [VEL_W-1:0]  v0_reg [3];
    logic [M_W-1:0]           m0_reg;
    logic [MOD_W-1:0]         mu0_reg;
    logic [RHO_W-1:0]         rho0_reg;
    logic                     kill0_reg, bad0_reg;
    logic [2:0]               mask0_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int d = 0; d < 3; d++)
            begin
                n0_reg[d] <= mask_in[d] ? n_in[d] : '0;
                v0_reg[d] <= v_in[d];
            end
            m0_reg    <= M_W'(lam_sel) + {1'b0, mu_sel, 1'b0};
            mu0_reg   <= mu_sel;
            rho0_reg  <= rho_sel;
            bad0_reg  <= (rho_sel == '0);
            kill0_reg <= (rho_sel == '0) || !s_tuser;
            mask0_reg <= mask_in;
        end
    end

    // stage 1: radicands and n*v products
    logic [RAD_W-1:0]         radp1_reg, rads1_reg;
    logic signed [NV_W-1:0]   nv1_reg [3];
    logic signed [NORM_W-1:0] n1_reg [3];
    logic signed [VEL_W-1:0]  v1_reg [3];
    logic                     kill1_reg, bad1_reg;
    logic [2:0]               mask1_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            radp1_reg <= rho0_reg * m0_reg;
            rads1_reg <= RAD_W'(rho0_reg * mu0_reg);
            for (int d = 0; d < 3; d++)
            begin
                nv1_reg[d] <= n0_reg[d] * v0_reg[d];
                n1_reg[d]  <= n0_reg[d];
                v1_reg[d]  <= v0_reg[d];
            end
            kill1_reg <= kill0_reg;
            bad1_reg  <= bad0_reg;
            mask1_reg <= mask0_reg;
        end
    end

    // square roots for the two impedances
    logic [ROOT_W-1:0] zp, zs;

    abt_isqrt #(.RAD_W(RAD_W)) u_sqrt_p (
        .clk  (clk),
        .en   (en[SQ_FIRST +: ROOT_W]),
        .rad  (radp1_reg),
        .root (zp)
    );

    abt_isqrt #(.RAD_W(RAD_W)) u_sqrt_s (
        .clk  (clk),
        .en   (en[SQ_FIRST +: ROOT_W]),
        .rad  (rads1_reg),
        .root (zs)
    );

    // stage 2: n.v rounded to q16
    logic signed [NV_W+2:0]   acc;
    logic signed [Q_W-1:0]    q2_reg;
    logic signed [NORM_W-1:0] n2_reg [3];
    logic signed [VEL_W-1:0]  v2_reg [3];
    logic                     kill2_reg, bad2_reg;
    logic [2:0]               mask2_reg;

    assign acc = (NV_W+3)'(nv1_reg[0]) + (NV_W+3)'(nv1_reg[1]) + (NV_W+3)'(nv1_reg[2])
               + (NV_W+3)'(32768);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            q2_reg <= acc[Q_W+15:16];
            for (int d = 0; d < 3; d++)
            begin
                n2_reg[d] <= n1_reg[d];
                v2_reg[d] <= v1_reg[d];
            end
            kill2_reg <= kill1_reg;
            bad2_reg  <= bad1_reg;
            mask2_reg <= mask1_reg;
        end
    end

    // stage 3: q*n
    logic signed [QN_W-1:0]  qn3_reg [3];
    logic signed [VEL_W-1:0] v3_reg [3];
    logic                    kill3_reg, bad3_reg;
    logic [2:0]              mask3_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int d = 0; d < 3; d++)
            begin
                qn3_reg[d] <= q2_reg * n2_reg[d];
                v3_reg[d]  <= v2_reg[d];
            end
            kill3_reg <= kill2_reg;
            bad3_reg  <= bad2_reg;
            mask3_reg <= mask2_reg;
        end
    end

    // stage 4: normal part p and tangential part w, then delayed to meet the roots
    logic signed [QN_W:0]  pr [3];
    logic signed [P_W-1:0] p4 [3];
    logic signed [P_W-1:0] w4 [3];
    side_t                 side_next;
    side_t                 side_reg [SIDE_ST:SQ_LAST];

    always_comb
    begin
        for (int d = 0; d < 3; d++)
        begin
            pr[d] = (QN_W+1)'(qn3_reg[d]) + (QN_W+1)'(32768);
            p4[d] = pr[d][P_W+15:16];
            w4[d] = P_W'(v3_reg[d]) - p4[d];
        end
        side_next.p_x  = p4[0];
        side_next.p_y  = p4[1];
        side_next.p_z  = p4[2];
        side_next.w_x  = w4[0];
        side_next.w_y  = w4[1];
        side_next.w_z  = w4[2];
        side_next.kill = kill3_reg;
        side_next.bad  = bad3_reg;
        side_next.mask = mask3_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = SIDE_ST; i <= SQ_LAST; i++)
        begin
            if (en[i])
                side_reg[i] <= (i == SIDE_ST) ? side_next : side_reg[(i == SIDE_ST) ? i : i - 1];
        end
    end

    // stage MUL: partial products of impedance times p and w, split on the operand
    logic signed [P_W-1:0]  op [6];
    logic signed [ROOT_W:0] zop [6];
    logic signed [PP_W-1:0] pph_reg [6];
    logic signed [PP_W-1:0] ppl_reg [6];
    logic                   kill_m_reg, bad_m_reg;
    logic [2:0]             mask_m_reg;

    always_comb
    begin
        op[0] = side_reg[SQ_LAST].p_x;
        op[1] = side_reg[SQ_LAST].p_y;
        op[2] = side_reg[SQ_LAST].p_z;
        op[3] = side_reg[SQ_LAST].w_x;
        op[4] = side_reg[SQ_LAST].w_y;
        op[5] = side_reg[SQ_LAST].w_z;
        for (int k = 0; k < 6; k++)
            zop[k] = (k < 3) ? $signed({1'b0, zp}) : $signed({1'b0, zs});
    end

    always_ff @(posedge clk)
    begin
        if (en[MUL_ST])
        begin
            for (int k = 0; k < 6; k++)
            begin
                pph_reg[k] <= zop[k] * $signed(op[k][P_W-1:18]);
                ppl_reg[k] <= zop[k] * $signed({1'b0, op[k][17:0]});
            end
            kill_m_reg <= side_reg[SQ_LAST].kill;
            bad_m_reg  <= side_reg[SQ_LAST].bad;
            mask_m_reg <= side_reg[SQ_LAST].mask;
        end
    end

    // stage CMB: full products, saturated
    logic signed [TR_W-1:0] prod_reg [6];
    logic                   kill_c_reg, bad_c_reg;
    logic [2:0]             mask_c_reg;

    always_ff @(posedge clk)
    begin
        if (en[CMB_ST])
        begin
            for (int k = 0; k < 6; k++)
                prod_reg[k] <= sat_prod($signed({pph_reg[k], 18'b0}) + PROD_W'(ppl_reg[k]));
            kill_c_reg <= kill_m_reg;
            bad_c_reg  <= bad_m_reg;
            mask_c_reg <= mask_m_reg;
        end
    end

    // stage OUT: saturating sum, component and zero-traction masking
    logic signed [TR_W-1:0] tr_reg [3];
    logic                   bad_o_reg;

    always_ff @(posedge clk)
    begin
        if (en[OUT_ST])
        begin
            for (int d = 0; d < 3; d++)
                tr_reg[d] <= (kill_c_reg || !mask_c_reg[d]) ? '0
                           : sat_sum(prod_reg[d], prod_reg[d+3]);
            bad_o_reg <= bad_c_reg;
        end
    end

    assign m_tvalid = valid_reg[OUT_ST];
    assign m_tdata  = {tr_reg[2], tr_reg[1], tr_reg[0]};
    assign m_tuser  = bad_o_reg;

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("bad material result with nonzero traction");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready && valid_reg == '1)
        else $error("input blocked while the pipeline has room");

    a_hold_first: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] && !en[1] |=> valid_reg[0])
        else $error("first stage dropped a stalled point");

    a_hold_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[SQ_LAST] && !en[MUL_ST] |=> valid_reg[SQ_LAST])
        else $error("root stage dropped a stalled point");

endmodule

// ----- tb/absorbing_boundary_traction_core_tb.sv -----
// self-checking testbench for the absorbing boundary traction core
`timescale 1ns / 1ps

module absorbing_boundary_traction_core_tb;

    import abt_pkg::*;

    typedef struct {
        logic signed [17:0] nx, ny, nz;
        logic signed [31:0] vx, vy, vz;
        logic               hv;
        logic [39:0]        lam, mu;
        logic [15:0]        rho;
    } point_t;

    typedef struct packed {
        logic [63:0] tx, ty, tz;
        logic        bad;
    } traction_t;

    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 5000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_DIMS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // mirror of the block's configuration registers
    logic [1:0]  cur_dims = 2'd3;
    logic        cur_use_point = 1'b0;
    logic [39:0] cur_lambda = '0;
    logic [39:0] cur_mu = '0;
    logic [15:0] cur_rho = 16'd1000;

    traction_t pending_tractions[$];
    int        mismatches = 0;
    int        points_sent = 0;
    int        tractions_checked = 0;
    int        bad_seen = 0;
    int        cfg_writes = 0;
    int        quiet_cycles = 0;
    bit        gaps_on = 1'b1;
    int        rx_stall = 0;

    absorbing_boundary_traction_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] probe;
        res = '0;
        probe = 64'd1 << 62;
        while (probe > x)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (x >= res + probe)
            begin
                x = x - (res + probe);
                res = (res >> 1) + probe;
            end
            else
                res = res >> 1;
            probe = probe >> 2;
        end
        return res;
    endfunction

    function automatic longint impedance_mul(input logic [63:0] z, input longint b);
        logic signed [129:0] za;
        logic signed [129:0] bb;
        logic signed [129:0] prod;
        za = $signed({66'd0, z});
        bb = b;
        prod = za * bb;
        if (prod > 130'sd9223372036854775807)
            return 64'h7fff_ffff_ffff_ffff;
        if (prod < -130'sd9223372036854775808)
            return 64'h8000_0000_0000_0000;
        return prod[63:0];
    endfunction

    function automatic longint clamp_add(input longint a, input longint b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
        return s[63:0];
    endfunction

    function automatic traction_t predict_traction(input point_t pt);
        longint      n[3];
        longint      v[3];
        longint      t[3];
        logic [63:0] lam, mu, rho, zp, zs;
        longint      acc, q, proj, tang;
        traction_t   r;
        n[0] = pt.nx; n[1] = pt.ny; n[2] = pt.nz;
        v[0] = pt.vx; v[1] = pt.vy; v[2] = pt.vz;
        t[0] = 0; t[1] = 0; t[2] = 0;
        lam = cur_use_point ? pt.lam : cur_lambda;
        mu  = cur_use_point ? pt.mu  : cur_mu;
        rho = cur_use_point ? pt.rho : cur_rho;
        r = '0;
        r.bad = (rho == 0);
        if (rho != 0 && pt.hv)
        begin
            zp = int_sqrt(rho * (lam + 2 * mu));
            zs = int_sqrt(rho * mu);
            acc = 0;
            for (int d = 0; d < cur_dims; d++)
                acc += n[d] * v[d];
            q = (acc + 32768) >>> 16;
            for (int d = 0; d < cur_dims; d++)
            begin
                proj = (q * n[d] + 32768) >>> 16;
                tang = v[d] - proj;
                t[d] = clamp_add(impedance_mul(zp, proj), impedance_mul(zs, tang));
            end
        end
        r.tx = t[0]; r.ty = t[1]; r.tz = t[2];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
    endtask

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        traction_t want;
        if (m_tvalid && m_tready)
        begin
            if (pending_tractions.size() == 0)
                report_mismatch("unexpected traction", m_tdata[63:0], 64'd0);
            else
            begin
                want = pending_tractions.pop_front();
                if (m_tdata[63:0] !== want.tx)
                    report_mismatch("traction_x", m_tdata[63:0], want.tx);
                if (m_tdata[127:64] !== want.ty)
                    report_mismatch("traction_y", m_tdata[127:64], want.ty);
                if (m_tdata[191:128] !== want.tz)
                    report_mismatch("traction_z", m_tdata[191:128], want.tz);
                if (m_tuser !== want.bad)
                    report_mismatch("bad_material", 64'(m_tuser), 64'(want.bad));
                if (want.bad)
                    bad_seen++;
            end
            tractions_checked++;
            rx_stall = gaps_on ? $urandom_range(0, 11) : 0;
        end
        if (rx_stall > 0)
        begin
            m_tready <= 1'b0;
            rx_stall--;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("absorbing_boundary_traction_core regression: fail");
            $finish;
        end
    end

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_tractions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [39:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DIMS:      cur_dims = value[1:0];
            CFG_USE_POINT: cur_use_point = value[0];
            CFG_LAMBDA:    cur_lambda = value;
            CFG_MU:        cur_mu = value;
            CFG_RHO:       cur_rho = value[15:0];
            default:       ;
        endcase
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic set_material(input logic [1:0] dims, input logic use_pt,
                                input logic [39:0] lam, input logic [39:0] mu,
                                input logic [15:0] rho);
        wait_drained();
        write_reg(CFG_DIMS, 40'(dims));
        write_reg(CFG_USE_POINT, 40'(use_pt));
        write_reg(CFG_LAMBDA, lam);
        write_reg(CFG_MU, mu);
        write_reg(CFG_RHO, 40'(rho));
    endtask

    task automatic send_point(input point_t pt);
        int gap;
        gap = gaps_on ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= pt.hv;
        s_tdata  <= {2'b00, pt.rho, pt.mu, pt.lam, pt.vz, pt.vy, pt.vx, pt.nz, pt.ny, pt.nx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_tractions.push_back(predict_traction(pt));
        points_sent++;
    endtask

    function automatic logic [39:0] rand40();
        return {$urandom(), $urandom()};
    endfunction

    // mostly physical points with occasional extreme fields
    function automatic point_t random_point();
        point_t pt;
        int     mode;
        mode = $urandom_range(0, 9);
        if (mode < 7)
        begin
            pt.nx = 18'($signed($urandom_range(0, 131072)) - 65536);
            pt.ny = 18'($signed($urandom_range(0, 131072)) - 65536);
            pt.nz = 18'($signed($urandom_range(0, 131072)) - 65536);
            pt.vx = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
            pt.vy = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
            pt.vz = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
        end
        else
        begin
            pt.nx = 18'($urandom()); pt.ny = 18'($urandom()); pt.nz = 18'($urandom());
            pt.vx = $urandom(); pt.vy = $urandom(); pt.vz = $urandom();
        end
        pt.hv  = ($urandom_range(0, 9) != 0);
        pt.lam = (mode == 9) ? 40'hff_ffff_ffff : rand40() >> $urandom_range(0, 39);
        pt.mu  = (mode == 8) ? 40'hff_ffff_ffff : rand40() >> $urandom_range(0, 39);
        pt.rho = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom());
        return pt;
    endfunction

    function automatic point_t make_point(input logic signed [17:0] nx, ny, nz,
                                          input logic signed [31:0] vx, vy, vz,
                                          input logic hv, input logic [15:0] rho);
        point_t pt;
        pt.nx = nx; pt.ny = ny; pt.nz = nz;
        pt.vx = vx; pt.vy = vy; pt.vz = vz;
        pt.hv = hv;
        pt.lam = 40'd3_000_000_000;
        pt.mu = 40'd1_500_000_000;
        pt.rho = rho;
        return pt;
    endfunction

    task automatic test_reset_defaults();
        // reset material is zero moduli, so traction should be zero
        repeat (3) send_point(random_point());
    endtask

    task automatic test_extremes();
        set_material(2'd3, 1'b0, 40'hff_ffff_ffff, 40'hff_ffff_ffff, 16'hffff);
        send_point(make_point(18'sd65536, 0, 0, 32'sd65536, 0, 0, 1'b1, 16'd1));
        send_point(make_point(0, -18'sd65536, 0, 0, 32'sd1 << 20, 32'sd5 << 16, 1'b1, 16'd1));
        send_point(make_point(18'sh1ffff, 18'sh1ffff, 18'sh1ffff,
                              32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b1, 16'd1));
        send_point(make_point(-18'sd131072, -18'sd131072, -18'sd131072,
                              -32'sd2147483648, -32'sd2147483648, -32'sd2147483648,
                              1'b1, 16'd1));
        send_point(make_point(18'sd46341, 18'sd46341, 0,
                              -32'sd2147483648, 32'sh7fffffff, 32'sd12345, 1'b1, 16'd1));
        send_point(make_point(18'sd65536, 0, 0, 32'sd65536, 0, 0, 1'b0, 16'd1));
        set_material(2'd3, 1'b0, 40'd20_000_000_000, 40'd10_000_000_000, 16'd2500);
        send_point(make_point(18'sd37837, 18'sd37837, 18'sd37837,
                              32'sd65536, -32'sd32768, 32'sd1, 1'b1, 16'd1));
        send_point(make_point(0, 0, 0, 32'sd100000, 32'sd100000, -32'sd100000, 1'b1, 16'd1));
    endtask

    task automatic test_zero_density();
        point_t pt;
        set_material(2'd3, 1'b0, 40'd1000, 40'd1000, 16'd0);
        send_point(make_point(18'sd65536, 0, 0, 32'sd65536, 0, 0, 1'b1, 16'd1));
        send_point(make_point(18'sd65536, 0, 0, 32'sd65536, 0, 0, 1'b0, 16'd1));
        set_material(2'd3, 1'b1, 40'd0, 40'd0, 16'd1000);
        send_point(make_point(18'sd65536, 0, 0, 32'sd65536, 0, 0, 1'b1, 16'd0));
        send_point(make_point(18'sd65536, 0, 0, 32'sd65536, 0, 0, 1'b0, 16'd0));
        pt = make_point(0, 18'sd65536, 0, 32'sd9 << 16, -32'sd3 << 16, 32'sd7, 1'b1, 16'hffff);
        pt.lam = 40'hff_ffff_ffff;
        pt.mu = 40'hff_ffff_ffff;
        send_point(pt);
    endtask

    task automatic test_dims();
        for (int d = 0; d < 4; d++)
        begin
            set_material(d[1:0], 1'b1, 40'd0, 40'd0, 16'd1000);
            repeat (2) send_point(random_point());
        end
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: set_material(2'd3, 1'b1, rand40(), rand40(), 16'($urandom()));
                    1: set_material(2'($urandom_range(0, 3)), 1'b0,
                                    rand40() >> $urandom_range(0, 39),
                                    rand40() >> $urandom_range(0, 39),
                                    16'($urandom()));
                    2: set_material(2'd1, 1'b0, 40'hff_ffff_ffff, 40'hff_ffff_ffff,
                                    16'hffff);
                    default: set_material(2'($urandom_range(1, 3)), 1'b1, 40'd0, 40'd0,
                                          16'd0);
                endcase
            end
            if (i % 150 == 75)
                gaps_on = ~gaps_on;
            // sender holds off until the pipe has emptied
            if (i == count / 2)
                wait_drained();
            send_point(random_point());
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_extremes();
        test_zero_density();
        test_dims();
        test_random(1030);
        wait_drained();
        $display("sent %0d boundary points, checked %0d tractions (%0d zero density)",
                 points_sent, tractions_checked, bad_seen);
        $display("%0d register writes over dims 0..3, point and constant material",
                 cfg_writes);
        if (mismatches == 0 && pending_tractions.size() == 0)
            $display("absorbing_boundary_traction_core regression: pass");
        else
            $display("absorbing_boundary_traction_core regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/abt_pkg.sv
hdl/abt_isqrt.sv
hdl/absorbing_boundary_traction_core.sv
tb/absorbing_boundary_traction_core_tb.sv
